>>> hw/rtl/hamming_secded_codec_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the SECDED codec
// Concurrent checks, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef HAMMING_SECDED_CODEC_TOP_ASSERT_SVH
`define HAMMING_SECDED_CODEC_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold on every clock outside reset.
`define HSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define HSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define HSC_ASSERT(label, clk, rst, prop, msg)
`define HSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define HSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> hw/rtl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Types, sizes and code-construction functions of the extended Hamming codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

   localparam int DATA_BITS   = 8;
   localparam int PARITY_BITS = 4;
   localparam int CODE_LEN    = DATA_BITS + PARITY_BITS;   // Hamming positions
   localparam int CODE_W      = CODE_LEN + 1;              // plus overall parity
   localparam int STATUS_W    = 2;

   // queue between front and back; depth must be a power of two
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NONE      = 2'd0,
      ST_CORRECTED = 2'd1,
      ST_DOUBLE    = 2'd2,
      ST_OVERALL   = 2'd3
   } status_type;

   typedef struct packed {
      op_type                  op;
      logic [CODE_W-1:0]       word;
      logic [PARITY_BITS-1:0]  syn;
      logic                    odd;
   } entry_type;

   function automatic logic is_parity_pos(input int p);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < PARITY_BITS; i++) begin
         if (p == (1 << i)) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic logic [CODE_W-1:0] encode(input logic [DATA_BITS-1:0] data);
      logic [CODE_W-1:0] w;
      logic              acc;
      int                d;
      w = '0;
      d = 0;
      for (int p = 1; p <= CODE_LEN; p++) begin
         if (!is_parity_pos(p)) begin
            if (d < DATA_BITS) w[p-1] = data[d];
            d++;
         end
      end
      for (int i = 0; i < PARITY_BITS; i++) begin
         acc = 1'b0;
         for (int p = 1; p <= CODE_LEN; p++) begin
            if (((p >> i) & 1) == 1) acc ^= w[p-1];
         end
         if ((1 << i) <= CODE_LEN) w[(1 << i) - 1] = acc;
      end
      w[CODE_LEN] = ^w[CODE_LEN-1:0];
      return w;
   endfunction

   function automatic logic [PARITY_BITS-1:0] syndrome_of(input logic [CODE_W-1:0] w);
      logic [PARITY_BITS-1:0] s;
      s = '0;
      for (int i = 0; i < PARITY_BITS; i++) begin
         for (int p = 1; p <= CODE_LEN; p++) begin
            if (((p >> i) & 1) == 1) s[i] ^= w[p-1];
         end
      end
      return s;
   endfunction

   function automatic logic [DATA_BITS-1:0] extract(input logic [CODE_W-1:0] w);
      logic [DATA_BITS-1:0] data;
      int                   d;
      data = '0;
      d = 0;
      for (int p = 1; p <= CODE_LEN; p++) begin
         if (!is_parity_pos(p)) begin
            if (d < DATA_BITS) data[d] = w[p-1];
            d++;
         end
      end
      return data;
   endfunction

endpackage

>>> hw/rtl/hsc_if.sv
// ----------------------------------------------------------------------------
// hsc_req_if / hsc_rsp_if
// Valid/ready channels carrying codec requests and responses.
// ----------------------------------------------------------------------------
interface hsc_req_if import hsc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [DATA_BITS-1:0] data_word;
   logic [CODE_W-1:0]    code_word;

   modport source (output valid, operation, data_word, code_word, input ready);
   modport sink   (input valid, operation, data_word, code_word, output ready);
endinterface

interface hsc_rsp_if import hsc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CODE_W-1:0]      code_out;
   logic [DATA_BITS-1:0]   data_out;
   logic [PARITY_BITS-1:0] syndrome;
   logic [STATUS_W-1:0]    status;

   modport source (output valid, code_out, data_out, syndrome, status, input ready);
   modport sink   (input valid, code_out, data_out, syndrome, status, output ready);
endinterface

>>> hw/rtl/hsc_front.sv
// ----------------------------------------------------------------------------
// hsc_front
// Accepts requests, encodes data words or forms syndrome and overall parity.
// ----------------------------------------------------------------------------
module hsc_front import hsc_pkg::*; (
   hsc_req_if.sink    req_ch,
   output logic       push_valid,
   output entry_type  push_entry,
   input  logic       push_ready
);

   op_type op;

   assign op           = op_type'(req_ch.operation);
   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

   always_comb begin
      push_entry.op = op;
      case (op)
         OP_ENCODE: begin
            push_entry.word = encode(req_ch.data_word);
            push_entry.syn  = '0;
            push_entry.odd  = 1'b0;
         end
         OP_DECODE: begin
            push_entry.word = req_ch.code_word;
            push_entry.syn  = syndrome_of(req_ch.code_word);
            push_entry.odd  = ^req_ch.code_word;
         end
         default: begin
            push_entry.word = '0;
            push_entry.syn  = '0;
            push_entry.odd  = 1'b0;
         end
      endcase
   end

endmodule

>>> hw/rtl/hsc_queue.sv
// ----------------------------------------------------------------------------
// hsc_queue
// Short register queue decoupling the front from the corrector.
// ----------------------------------------------------------------------------
`include "hamming_secded_codec_top_assert.svh"

module hsc_queue import hsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  entry_type  push_entry,
   output logic       push_ready,
   output logic       pop_valid,
   output entry_type  pop_entry,
   input  logic       pop_ready
);

   entry_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   `HSC_ASSERT(a_q_count_range, clock, reset, count_ff <= QCNT_W'(QDEPTH), "queue count overflow")
   `HSC_ASSERT_NEXT(a_q_push_fills, clock, reset, push && !pop, count_ff != '0, "push lost")

endmodule

>>> hw/rtl/hsc_back.sv
// ----------------------------------------------------------------------------
// hsc_back
// Corrects single errors, classifies the word and holds the response register.
// ----------------------------------------------------------------------------
`include "hamming_secded_codec_top_assert.svh"

module hsc_back import hsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head_entry,
   output logic       head_ready,
   hsc_rsp_if.source  rsp_ch
);

   logic                   valid_ff, valid_in;
   logic [CODE_W-1:0]      code_ff, code_in;
   logic [DATA_BITS-1:0]   data_ff, data_in;
   logic [PARITY_BITS-1:0] syn_ff, syn_in;
   status_type             status_ff, status_in;
   logic [CODE_W-1:0]      flip;
   logic                   load;

   assign head_ready = !valid_ff || rsp_ch.ready;
   assign load       = head_valid && head_ready;

   // one-hot flip mask for a syndrome naming a Hamming position
   always_comb begin
      flip = '0;
      for (int p = 1; p <= CODE_LEN; p++) begin
         flip[p-1] = (int'(head_entry.syn) == p);
      end
   end

   always_comb begin
      code_in   = head_entry.word;
      syn_in    = '0;
      status_in = ST_NONE;
      case (head_entry.op)
         OP_ENCODE: begin
            code_in = head_entry.word;
         end
         OP_DECODE: begin
            syn_in = head_entry.syn;
            if (head_entry.syn == '0) begin
               if (head_entry.odd) begin
                  code_in   = head_entry.word ^ {1'b1, {CODE_LEN{1'b0}}};
                  status_in = ST_OVERALL;
               end
            end else if (head_entry.odd && (int'(head_entry.syn) <= CODE_LEN)) begin
               code_in   = head_entry.word ^ flip;
               status_in = ST_CORRECTED;
            end else begin
               status_in = ST_DOUBLE;
            end
         end
         default: begin
            code_in = head_entry.word;
         end
      endcase
      data_in  = (head_entry.op == OP_DECODE) ? extract(code_in) : '0;
      valid_in = head_ready ? head_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff   <= code_in;
         data_ff   <= data_in;
         syn_ff    <= syn_in;
         status_ff <= status_in;
      end
   end

   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.code_out = code_ff;
   assign rsp_ch.data_out = data_ff;
   assign rsp_ch.syndrome = syn_ff;
   assign rsp_ch.status   = status_ff;

   // anything but a double error leaves a word with even overall parity
   `HSC_ASSERT_IMPL(a_b_even_out, clock, reset, valid_ff && status_ff != ST_DOUBLE, ^code_ff == 1'b0, "odd parity on clean word")
   `HSC_ASSERT_IMPL(a_b_corr_syn, clock, reset, valid_ff && status_ff == ST_CORRECTED, syn_ff != '0, "correction without syndrome")

endmodule

>>> hw/rtl/hamming_secded_codec_top.sv
// ----------------------------------------------------------------------------
// hamming_secded_codec_top
// Extended Hamming (13,8) SECDED encoder / decoder. Takes one request per
// clock while req_ch.ready is high and returns one response per request, in
// order. An accepted request is written into the queue and then into the
// corrector's response register, which drives rsp_ch. Throughput is one
// item per clock, the front feeding a two-entry queue that drains into
// the response register; a stalled response side backs up the queue before
// req_ch.ready drops. No configuration, no state to reset beyond the handshake
// control.
// ----------------------------------------------------------------------------
module hamming_secded_codec_top import hsc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   hsc_req_if.sink   req_ch,
   hsc_rsp_if.source rsp_ch
);

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      head_valid, head_ready;
   entry_type head_entry;

   hsc_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   hsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (head_valid),
      .pop_entry  (head_entry),
      .pop_ready  (head_ready)
   );

   hsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_ready (head_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule
